FILE: rtl/core/sntpc_pkg.sv
// Shared types, constants and the request table of the SNTP client timekeeper.
`timescale 1ns / 1ps

package sntpc_pkg;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_BYTE = 1'b1
  } req_kind_t;

  typedef enum logic {
    KIND_REPORT  = 1'b0,
    KIND_REQUEST = 1'b1
  } out_kind_t;

  typedef enum logic {
    CFG_SYNC_INTERVAL = 1'b0,
    CFG_WAIT_LIMIT    = 1'b1
  } cfg_reg_t;

  localparam logic [5:0]  PACKET_BYTES = 6'd48;
  localparam logic [5:0]  SEC_FIRST    = 6'd40;
  localparam logic [5:0]  SEC_LAST     = 6'd43;
  localparam logic [5:0]  FRAC_FIRST   = 6'd44;
  localparam logic [5:0]  FRAC_LAST    = 6'd47;
  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
  localparam logic [9:0]  MS_LAST      = 10'd999;
  localparam logic [31:0] EPOCH_OFFSET = 32'd2208988800;
  localparam logic [31:0] SYNC_INTERVAL_RESET = 32'd3600;
  localparam logic [15:0] WAIT_LIMIT_RESET    = 16'd2000;

  typedef struct packed {
    req_kind_t  req_type;
    logic [7:0] rx_byte;
    logic       rx_end;
  } in_item_t;

  typedef struct packed {
    logic       waiting;
    logic [1:0] leap;
    logic       synced;
    logic [9:0] millis;
    logic [31:0] seconds;
  } status_t;

  function automatic logic [7:0] request_byte(input logic [5:0] idx);
    logic [7:0] b;
    unique case (idx)
      6'd0:    b = 8'hE3;
      6'd2:    b = 8'h06;
      6'd3:    b = 8'hEC;
      6'd12:   b = 8'h31;
      6'd13:   b = 8'h4E;
      6'd14:   b = 8'h31;
      6'd15:   b = 8'h34;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/sntpc_core.sv
// Timekeeping state, reply capture and configuration registers of the SNTP client.
`timescale 1ns / 1ps

module sntpc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sntpc_pkg::in_item_t item,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [31:0]       cfg_data,
  output logic              send,
  output sntpc_pkg::status_t stat_cur,
  output sntpc_pkg::status_t stat_nxt
);
  import sntpc_pkg::*;

  logic [31:0] sec_r, sec_nxt;
  logic [9:0]  ms_r, ms_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic        synced_r, synced_nxt;
  logic [1:0]  leap_r, leap_nxt;
  logic        wait_r, wait_nxt;
  logic [15:0] wcnt_r, wcnt_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] cap_sec_r, cap_sec_nxt;
  logic [31:0] cap_frac_r, cap_frac_nxt;
  logic [1:0]  cap_leap_r, cap_leap_nxt;
  logic [31:0] intv_adj_r;
  logic [15:0] wait_limit_r;

  always_comb begin
    logic [15:0] wcnt_inc;
    logic [41:0] frac_prod;
    sec_nxt      = sec_r;
    ms_nxt       = ms_r;
    deadline_nxt = deadline_r;
    synced_nxt   = synced_r;
    leap_nxt     = leap_r;
    wait_nxt     = wait_r;
    wcnt_nxt     = wcnt_r;
    pos_nxt      = pos_r;
    cap_sec_nxt  = cap_sec_r;
    cap_frac_nxt = cap_frac_r;
    cap_leap_nxt = cap_leap_r;
    send         = 1'b0;
    wcnt_inc     = wcnt_r + 16'd1;
    frac_prod    = '0;
    unique case (item.req_type)
      REQ_TICK: begin
        if (ms_r >= MS_LAST) begin
          ms_nxt  = '0;
          sec_nxt = sec_r + 32'd1;
        end else begin
          ms_nxt = ms_r + 10'd1;
        end
        if (wait_r) begin
          wcnt_nxt = wcnt_inc;
          if (wcnt_inc >= wait_limit_r || wcnt_inc == 16'd0) begin
            wait_nxt = 1'b0;
            wcnt_nxt = '0;
          end
        end
        if (sec_nxt >= deadline_r && !wait_nxt) begin
          synced_nxt = 1'b0;
          wait_nxt   = 1'b1;
          wcnt_nxt   = '0;
          pos_nxt    = '0;
          send       = 1'b1;
        end
      end
      REQ_BYTE: begin
        if (wait_r && pos_r < PACKET_BYTES) begin
          if (pos_r == 6'd0) begin
            cap_leap_nxt = item.rx_byte[7:6];
          end else if (pos_r >= SEC_FIRST && pos_r <= SEC_LAST) begin
            cap_sec_nxt = {cap_sec_r[23:0], item.rx_byte};
          end else if (pos_r >= FRAC_FIRST && pos_r <= FRAC_LAST) begin
            cap_frac_nxt = {cap_frac_r[23:0], item.rx_byte};
          end
          pos_nxt = pos_r + 6'd1;
        end
        frac_prod = 42'(cap_frac_nxt) * 42'(MS_PER_SEC);
        if (item.rx_end) begin
          if (wait_r && pos_nxt >= PACKET_BYTES) begin
            sec_nxt      = cap_sec_nxt - EPOCH_OFFSET;
            ms_nxt       = frac_prod[41:32];
            deadline_nxt = cap_sec_nxt + intv_adj_r;
            synced_nxt   = 1'b1;
            leap_nxt     = cap_leap_nxt;
            wait_nxt     = 1'b0;
            wcnt_nxt     = '0;
          end
          pos_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r        <= '0;
      ms_r         <= '0;
      deadline_r   <= '0;
      synced_r     <= 1'b0;
      leap_r       <= '0;
      wait_r       <= 1'b0;
      wcnt_r       <= '0;
      pos_r        <= '0;
      cap_sec_r    <= '0;
      cap_frac_r   <= '0;
      cap_leap_r   <= '0;
      intv_adj_r   <= SYNC_INTERVAL_RESET - EPOCH_OFFSET;
      wait_limit_r <= WAIT_LIMIT_RESET;
    end else begin
      if (fire) begin
        sec_r      <= sec_nxt;
        ms_r       <= ms_nxt;
        deadline_r <= deadline_nxt;
        synced_r   <= synced_nxt;
        leap_r     <= leap_nxt;
        wait_r     <= wait_nxt;
        wcnt_r     <= wcnt_nxt;
        pos_r      <= pos_nxt;
        cap_sec_r  <= cap_sec_nxt;
        cap_frac_r <= cap_frac_nxt;
        cap_leap_r <= cap_leap_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          CFG_SYNC_INTERVAL: intv_adj_r   <= cfg_data - EPOCH_OFFSET;
          CFG_WAIT_LIMIT:    wait_limit_r <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign stat_cur = '{waiting: wait_r, leap: leap_r, synced: synced_r,
                      millis: ms_r, seconds: sec_r};
  assign stat_nxt = '{waiting: wait_nxt, leap: leap_nxt, synced: synced_nxt,
                      millis: ms_nxt, seconds: sec_nxt};

endmodule

FILE: rtl/core/sntp_client_timekeeper_unit.sv
// Top level of the SNTP client timekeeper: input stage, request burst and result register.
`timescale 1ns / 1ps

// Channel | Dir | Ports                       | Contents
// in      | in  | in_tvalid/tready/tdata/...  | tick or reply byte; tlast ends a reply
// out     | out | out_tvalid/tready/tdata/... | request bytes and time reports
// cfg     | in  | cfg_valid/ready/addr/data   | sync interval, wait limit
//
// A request enters an input register and is processed from there unless a request burst
// or a stalled output holds it; one request per cycle is taken while results flow freely
// and no burst runs. A tick that starts an exchange holds the input side while the result
// register sends the 48 request bytes and the report. Reset is synchronous and active
// low; reply bytes that give no result proceed even while the output stalls.

module sntp_client_timekeeper_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] req_type
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] tx_byte, [39:8] unix_seconds,
                                  // [49:40] millis_part, [50] synced, [52:51] leap,
                                  // [53] waiting, [55:54] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_data
);
  import sntpc_pkg::*;

  logic      in_v_r;
  in_item_t  in_item_r;
  logic      burst_r, burst_nxt;
  logic [5:0] bcnt_r, bcnt_nxt;
  logic      out_v_r, out_v_nxt;
  out_kind_t out_kind_r, out_kind_nxt;
  logic [7:0] out_tx_r, out_tx_nxt;
  logic      out_last_r, out_last_nxt;
  status_t   out_stat_r, out_stat_nxt;

  logic      send;
  status_t   stat_cur, stat_nxt;
  logic      produces, out_ok, fire;

  assign produces  = (in_item_r.req_type == REQ_TICK) || in_item_r.rx_end;
  assign out_ok    = !out_v_r || out_tready;
  assign fire      = in_v_r && !burst_r && (!produces || out_ok);
  assign in_tready = !in_v_r || fire;
  assign cfg_ready = 1'b1;

  sntpc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (in_item_r),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .send     (send),
    .stat_cur (stat_cur),
    .stat_nxt (stat_nxt)
  );

  always_comb begin
    burst_nxt    = burst_r;
    bcnt_nxt     = bcnt_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_kind_nxt = out_kind_r;
    out_tx_nxt   = out_tx_r;
    out_last_nxt = out_last_r;
    out_stat_nxt = out_stat_r;
    priority if (burst_r && out_ok) begin
      out_v_nxt    = 1'b1;
      out_stat_nxt = stat_cur;
      if (bcnt_r == PACKET_BYTES) begin
        out_kind_nxt = KIND_REPORT;
        out_tx_nxt   = '0;
        out_last_nxt = 1'b1;
        burst_nxt    = 1'b0;
      end else begin
        out_kind_nxt = KIND_REQUEST;
        out_tx_nxt   = request_byte(bcnt_r);
        out_last_nxt = 1'b0;
        bcnt_nxt     = bcnt_r + 6'd1;
      end
    end else if (fire && produces) begin
      out_v_nxt    = 1'b1;
      out_stat_nxt = stat_nxt;
      if (send) begin
        out_kind_nxt = KIND_REQUEST;
        out_tx_nxt   = request_byte(6'd0);
        out_last_nxt = 1'b0;
        burst_nxt    = 1'b1;
        bcnt_nxt     = 6'd1;
      end else begin
        out_kind_nxt = KIND_REPORT;
        out_tx_nxt   = '0;
        out_last_nxt = 1'b1;
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      burst_r <= 1'b0;
      bcnt_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      burst_r <= burst_nxt;
      bcnt_r  <= bcnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= '{req_type: req_kind_t'(in_tuser), rx_byte: in_tdata, rx_end: in_tlast};
    end
    out_kind_r <= out_kind_nxt;
    out_tx_r   <= out_tx_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_stat_r, out_tx_r};

endmodule

FILE: sim/timekeeper_result_check.sv
// Predicts and checks the time reports and request bytes of the SNTP client timekeeper.
`timescale 1ns / 1ps

module timekeeper_result_check
  import sntpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    out_kind_t   kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] seconds;
    logic [9:0]  millis;
    logic        synced;
    logic [1:0]  leap;
    logic        waiting;
  } time_result_t;

  time_result_t expected_results[$];
  time_result_t want;
  time_result_t got;

  logic [31:0] interval_q;
  logic [15:0] wait_limit_q;
  logic [31:0] clk_seconds;
  logic [9:0]  clk_millis;
  logic [31:0] deadline;
  logic        synced_q;
  logic [1:0]  leap_q;
  logic        waiting_q;
  logic [15:0] wait_count;
  logic [5:0]  rx_pos;
  logic [31:0] rx_seconds;
  logic [31:0] rx_fraction;
  logic [1:0]  rx_leap;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [7:0] request_octet(input int unsigned pos);
    case (pos)
      0:       return 8'hE3;
      2:       return 8'h06;
      3:       return 8'hEC;
      12, 14:  return 8'h31;
      13:      return 8'h4E;
      15:      return 8'h34;
      default: return 8'h00;
    endcase
  endfunction

  task automatic queue_result(input out_kind_t kind, input logic [7:0] tx, input logic last);
    time_result_t r;
    r.kind = kind;
    r.tx_byte = tx;
    r.last = last;
    r.seconds = clk_seconds;
    r.millis = clk_millis;
    r.synced = synced_q;
    r.leap = leap_q;
    r.waiting = waiting_q;
    expected_results.push_back(r);
  endtask

  task automatic apply_tick();
    logic        send_request;
    int unsigned pos;
    send_request = 1'b0;
    if (clk_millis >= MS_LAST) begin
      clk_millis = '0;
      clk_seconds = clk_seconds + 32'd1;
    end else begin
      clk_millis = clk_millis + 10'd1;
    end
    if (waiting_q) begin
      wait_count = wait_count + 16'd1;
      if (wait_count >= wait_limit_q || wait_count == 16'd0) begin
        waiting_q = 1'b0;
        wait_count = '0;
      end
    end
    if (clk_seconds >= deadline && !waiting_q) begin
      synced_q = 1'b0;
      waiting_q = 1'b1;
      wait_count = '0;
      rx_pos = '0;
      send_request = 1'b1;
    end
    if (send_request) begin
      for (pos = 0; pos < PACKET_BYTES; pos++) begin
        queue_result(KIND_REQUEST, request_octet(pos), 1'b0);
      end
    end
    queue_result(KIND_REPORT, 8'h00, 1'b1);
  endtask

  task automatic apply_byte(input logic [7:0] b, input logic fin);
    logic [63:0] scaled;
    if (waiting_q && rx_pos < PACKET_BYTES) begin
      if (rx_pos == 6'd0) begin
        rx_leap = b[7:6];
      end else if (rx_pos >= SEC_FIRST && rx_pos <= SEC_LAST) begin
        rx_seconds = {rx_seconds[23:0], b};
      end else if (rx_pos >= FRAC_FIRST && rx_pos <= FRAC_LAST) begin
        rx_fraction = {rx_fraction[23:0], b};
      end
      rx_pos = rx_pos + 6'd1;
    end
    if (fin) begin
      if (waiting_q && rx_pos >= PACKET_BYTES) begin
        scaled = {32'd0, rx_fraction} * 64'd1000;
        clk_seconds = rx_seconds - EPOCH_OFFSET;
        clk_millis = scaled[41:32];
        deadline = clk_seconds + interval_q;
        synced_q = 1'b1;
        leap_q = rx_leap;
        waiting_q = 1'b0;
        wait_count = '0;
      end
      rx_pos = '0;
      queue_result(KIND_REPORT, 8'h00, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      interval_q = SYNC_INTERVAL_RESET;
      wait_limit_q = WAIT_LIMIT_RESET;
      clk_seconds = '0;
      clk_millis = '0;
      deadline = '0;
      synced_q = 1'b0;
      leap_q = '0;
      waiting_q = 1'b0;
      wait_count = '0;
      rx_pos = '0;
      rx_seconds = '0;
      rx_fraction = '0;
      rx_leap = '0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind = out_kind_t'(out_tuser);
        got.tx_byte = out_tdata[7:0];
        got.last = out_tlast;
        got.seconds = out_tdata[39:8];
        got.millis = out_tdata[49:40];
        got.synced = out_tdata[50];
        got.leap = out_tdata[52:51];
        got.waiting = out_tdata[53];
        if (expected_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result: kind %0d tx %02h last %0d sec %08h ms %0d",
                     got.kind, got.tx_byte, got.last, got.seconds, got.millis);
          end
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== got.kind || want.tx_byte !== got.tx_byte ||
              want.last !== got.last || want.seconds !== got.seconds ||
              want.millis !== got.millis || want.synced !== got.synced ||
              want.leap !== got.leap || want.waiting !== got.waiting) begin
            if (fail_count < 10) begin
              $display("result mismatch: expected kind %0d tx %02h last %0d sec %08h ms %0d",
                       want.kind, want.tx_byte, want.last, want.seconds, want.millis,
                       " synced %0d leap %0d waiting %0d", want.synced, want.leap,
                       want.waiting);
              $display("                 actual   kind %0d tx %02h last %0d sec %08h ms %0d",
                       got.kind, got.tx_byte, got.last, got.seconds, got.millis,
                       " synced %0d leap %0d waiting %0d", got.synced, got.leap,
                       got.waiting);
            end
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == CFG_SYNC_INTERVAL) begin
          interval_q = cfg_data;
        end else begin
          wait_limit_q = cfg_data[15:0];
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_TICK) begin
          apply_tick();
        end else begin
          apply_byte(in_tdata, in_tlast);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: sim/sntp_client_timekeeper_unit_tb.sv
// Stimulus, clocking and verdict for the SNTP client timekeeper testbench.
`timescale 1ns / 1ps

module sntp_client_timekeeper_unit_tb;
  import sntpc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_addr;
  logic [31:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          steady;

  sntp_client_timekeeper_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  timekeeper_result_check result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sntp_client_timekeeper_unit_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned hold;
    int unsigned gap;
    out_tready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    out_tready <= 1'b1;
    forever begin
      hold = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
      repeat (hold) @(negedge clk);
      gap = idle_gap();
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input req_kind_t kind, input logic [7:0] data, input logic fin,
                              input bit counted);
    int unsigned idle;
    idle = steady ? 0 : idle_gap();
    if (idle != 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= data;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (counted) items_sent++;
  endtask

  task automatic send_tick();
    send_request(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic send_reply(input int unsigned len, input logic [7:0] first,
                            input logic [31:0] secs, input logic [31:0] frac,
                            input bit random_fill, input logic [7:0] fill);
    int unsigned pos;
    logic [7:0]  b;
    for (pos = 0; pos < len; pos++) begin
      if (pos == 0) b = first;
      else if (pos >= 40 && pos <= 43) b = secs[8*(43-pos) +: 8];
      else if (pos >= 44 && pos <= 47) b = frac[8*(47-pos) +: 8];
      else if (random_fill) b = 8'($urandom_range(0, 255));
      else b = fill;
      send_request(REQ_BYTE, b, pos == len - 1, 1'b1);
    end
  endtask

  task automatic set_register(input cfg_reg_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the sender off until every expected result is out, plus the pipeline depth.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_scenario(input bit hi_frac);
    int unsigned sel;
    int unsigned n;
    int unsigned k;
    logic [31:0] frac;
    sel = $urandom_range(0, 99);
    steady = ($urandom_range(0, 9) == 0);
    frac = $urandom;
    if (hi_frac) frac[31:24] = 8'hFF;
    if (sel < 45) begin
      send_tick();
      n = ($urandom_range(0, 3) == 0) ? PACKET_BYTES + $urandom_range(1, 8) : PACKET_BYTES;
      send_reply(n, 8'($urandom_range(0, 255)), $urandom, frac, 1'b1, 8'h00);
    end else if (sel < 60) begin
      if ($urandom_range(0, 1) == 1) send_tick();
      send_reply($urandom_range(1, PACKET_BYTES - 1), 8'($urandom_range(0, 255)), $urandom,
                 frac, 1'b1, 8'h00);
    end else if (sel < 85) begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) send_tick();
    end else if (sel < 95) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        send_request(REQ_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      end
    end else begin
      send_reply(PACKET_BYTES, 8'($urandom_range(0, 255)), $urandom, frac, 1'b1, 8'h00);
    end
  endtask

  task automatic run_phase(input logic [31:0] interval, input logic [15:0] limit,
                           input bit hi_frac, input int unsigned count);
    int unsigned budget;
    settle();
    set_register(CFG_SYNC_INTERVAL, interval);
    set_register(CFG_WAIT_LIMIT, {16'd0, limit});
    cfg_valid <= 1'b0;
    budget = items_sent + count;
    while (items_sent < budget) run_scenario(hi_frac);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_TICK;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = CFG_SYNC_INTERVAL;
    cfg_data = '0;
    items_sent = 0;
    idle_cycles = 0;
    steady = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: the deadline of zero is due on the first tick.
    send_tick();
    settle();
    set_register(CFG_SYNC_INTERVAL, 32'd1);
    set_register(CFG_WAIT_LIMIT, 32'd3);
    cfg_valid <= 1'b0;
    send_reply(5, 8'h9C, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 8'h00);
    send_reply(50, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'hFF);
    send_request(REQ_BYTE, 8'h00, 1'b1, 1'b1);
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    send_reply(PACKET_BYTES, 8'h00, 32'h0000_0000, 32'hFF00_0000, 1'b0, 8'h00);
    send_tick();
    send_tick();
    send_tick();
    send_tick();

    run_phase(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 20);
    run_phase(32'd1, 16'd1, 1'b1, 20);
    run_phase(32'd0, 16'd0, 1'b0, 20);
    run_phase(32'hFFFF_FFFF - $urandom_range(0, 255), 16'($urandom_range(2, 12)), 1'b0, 20);
    run_phase(32'd1, 16'($urandom_range(2, 40)), 1'b1, 20);

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sntp_client_timekeeper_unit_tb: clean");
    end else begin
      $display("sntp_client_timekeeper_unit_tb: errors");
    end
    $finish;
  end

endmodule
